>>> hdl/kmnc_pkg.sv
// Shared types and constants for the k-means nearest-centroid block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package kmnc_pkg;

    localparam int MAX_CENTROIDS = 16;
    localparam int MAX_FEATURES  = 16;

    localparam int CIDX_W    = $clog2(MAX_CENTROIDS);
    localparam int FIDX_W    = $clog2(MAX_FEATURES);
    localparam int CNT_W     = 5;
    localparam int VALUE_W   = 16;
    localparam int ABS_W     = VALUE_W + 1;
    localparam int SQ_W      = 2 * ABS_W;
    localparam int PART_W    = 37;
    localparam int DIST_W    = 36;
    localparam int INERTIA_W = 48;
    localparam int STORE_AW  = CIDX_W + FIDX_W;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 88;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_POINT = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CENTROIDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_FEATURES  = 1'b1;

    // One centroid slot handed from the sequencer to the distance pipeline.
    typedef struct packed {
        logic              vld;
        logic [CIDX_W-1:0] cidx;
        logic              zero;   // first feature of a point: partial sums start at zero
        logic              first;  // first centroid of the pass
        logic              last;   // last active centroid of the pass
    } kmnc_issue_t;

    typedef struct packed {
        logic              done;
        logic [CIDX_W-1:0] label;
        logic [PART_W-1:0] best_sum;
    } kmnc_result_t;

endpackage

`default_nettype wire

>>> hdl/kmnc_centroid_mem.sv
// Centroid table: one word per (centroid, feature), synchronous read.
// Depends on kmnc_pkg.
`default_nettype none

module kmnc_centroid_mem
    import kmnc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [STORE_AW-1:0] wr_addr,
    input  wire logic [VALUE_W-1:0]  wr_data,
    input  wire logic                rd_en,
    input  wire logic [STORE_AW-1:0] rd_addr,
    output logic      [VALUE_W-1:0]  rd_data
);

    logic [VALUE_W-1:0] mem [MAX_CENTROIDS*MAX_FEATURES];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/kmnc_accum.sv
// Distance pipeline: read partial sum, square the difference, add, write back,
// and track the smallest sum of the pass. Depends on kmnc_pkg.
`default_nettype none

module kmnc_accum
    import kmnc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire kmnc_issue_t        issue,
    input  wire logic [VALUE_W-1:0] point_value,
    input  wire logic [VALUE_W-1:0] cent_data,
    output kmnc_result_t            result
);

    localparam logic [PART_W-1:0] PART_MAX = {PART_W{1'b1}};

    logic [PART_W-1:0]        part_mem [MAX_CENTROIDS];
    logic [MAX_CENTROIDS-1:0] part_valid_reg;

    kmnc_issue_t        s1_reg, s2_reg, s3_reg;
    logic [PART_W-1:0]  part1_reg, part2_reg, part3_reg;
    logic               part1_vld_reg;
    logic [ABS_W-1:0]   abs_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [CIDX_W-1:0]  best_label_reg;
    logic [PART_W-1:0]  best_dist_reg;
    logic               done_reg;

    logic signed [ABS_W-1:0] diff;
    logic [ABS_W-1:0]        abs_next;
    logic [PART_W:0]         sum_wide;
    logic [PART_W-1:0]       sum_next;

    always_comb begin
        diff     = $signed({point_value[VALUE_W-1], point_value})
                 - $signed({cent_data[VALUE_W-1], cent_data});
        abs_next = diff[ABS_W-1] ? ABS_W'(-diff) : ABS_W'(diff);
        sum_wide = {1'b0, part3_reg} + (PART_W+1)'(sq_reg);
        sum_next = sum_wide[PART_W] ? PART_MAX : sum_wide[PART_W-1:0];
    end

    // Partial sum store; a read and a write in one cycle always hit different rows.
    always_ff @(posedge aclk) begin
        if (issue.vld) begin
            part1_reg <= part_mem[issue.cidx];
        end
        if (s3_reg.vld) begin
            part_mem[s3_reg.cidx] <= sum_next;
        end
        part2_reg <= part1_vld_reg ? part1_reg : '0;
        abs_reg   <= abs_next;
        part3_reg <= part2_reg;
        sq_reg    <= SQ_W'(abs_reg * abs_reg);
        if (s3_reg.vld && (s3_reg.first || sum_next < best_dist_reg)) begin
            best_dist_reg  <= sum_next;
            best_label_reg <= s3_reg.cidx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_valid_reg <= '0;
            part1_vld_reg  <= 1'b0;
            s1_reg         <= '0;
            s2_reg         <= '0;
            s3_reg         <= '0;
            done_reg       <= 1'b0;
        end else begin
            // A new point forgets every partial sum, also of inactive rows.
            if (issue.vld && issue.zero && issue.first) begin
                part_valid_reg <= '0;
            end
            if (s3_reg.vld) begin
                part_valid_reg[s3_reg.cidx] <= 1'b1;
            end
            part1_vld_reg <= part_valid_reg[issue.cidx] && !issue.zero;
            s1_reg        <= issue;
            s2_reg        <= s1_reg;
            s3_reg        <= s2_reg;
            done_reg      <= s3_reg.vld && s3_reg.last;
        end
    end

    assign result.done     = done_reg;
    assign result.label    = best_label_reg;
    assign result.best_sum = best_dist_reg;

endmodule

`default_nettype wire

>>> hdl/kmeans_nearest_centroid.sv
// K-means assignment step: a point feature beat holds s_tready low while one centroid per
// cycle passes through the partial-sum memory, a three-stage pipeline and a return register,
// so the block takes no new beat until that feature is through. The last feature adds a
// finish state; its result beat waits there while an earlier result stalls. Write, clear
// and ignored beats leave s_tready high.
// Synchronous active-low reset clears control, partial sums and inertia; counts go to 1 and 16.
`default_nettype none

module kmeans_nearest_centroid
    import kmnc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // centroid_index [3:0], feature_index [7:4], value [23:8]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // action [1:0]
    input  wire logic [ACTION_W-1:0]  s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // label [3:0], distance [39:4], inertia_sum [87:40]
    output logic      [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_wdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_FINISH} state_t;

    localparam logic [CNT_W-1:0]     MAX_C    = CNT_W'(MAX_CENTROIDS);
    localparam logic [CNT_W-1:0]     MAX_F    = CNT_W'(MAX_FEATURES);
    localparam logic [DIST_W-1:0]    DIST_MAX = {DIST_W{1'b1}};
    localparam logic [INERTIA_W-1:0] INER_MAX = {INERTIA_W{1'b1}};

    state_t                 state_reg;
    logic [CNT_W-1:0]       active_centroids_reg;
    logic [CNT_W-1:0]       active_features_reg;
    logic [CIDX_W-1:0]      c_reg;
    logic [FIDX_W-1:0]      fi_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic                   last_item_reg;
    logic [INERTIA_W-1:0]   inertia_reg;
    logic                   m_tvalid_reg;
    logic [CIDX_W-1:0]      label_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic [INERTIA_W-1:0]   m_inertia_reg;

    logic [CNT_W-1:0]       nc_eff, nf_eff;
    logic [CIDX_W-1:0]      in_cidx;
    logic [FIDX_W-1:0]      in_fidx;
    logic [VALUE_W-1:0]     in_value;
    logic                   in_beat;
    logic                   finish_fire;
    logic [DIST_W-1:0]      dist_next;
    logic [INERTIA_W:0]     inertia_wide;
    logic [INERTIA_W-1:0]   inertia_next;
    logic [VALUE_W-1:0]     cent_data;
    kmnc_issue_t            issue;
    kmnc_result_t           result;

    always_comb begin
        if (active_centroids_reg == '0) begin
            nc_eff = CNT_W'(1);
        end else if (active_centroids_reg > MAX_C) begin
            nc_eff = MAX_C;
        end else begin
            nc_eff = active_centroids_reg;
        end
        if (active_features_reg == '0) begin
            nf_eff = CNT_W'(1);
        end else if (active_features_reg > MAX_F) begin
            nf_eff = MAX_F;
        end else begin
            nf_eff = active_features_reg;
        end
    end

    assign in_cidx  = s_tdata[CIDX_W-1:0];
    assign in_fidx  = s_tdata[CIDX_W+FIDX_W-1:CIDX_W];
    assign in_value = s_tdata[CIDX_W+FIDX_W+VALUE_W-1:CIDX_W+FIDX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    // The result register loads only when it is empty or being read this cycle.
    assign finish_fire = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb begin
        issue.vld   = (state_reg == ST_ISSUE);
        issue.cidx  = c_reg;
        issue.zero  = (fi_reg == '0);
        issue.first = (c_reg == '0);
        issue.last  = ({1'b0, c_reg} == nc_eff - CNT_W'(1));
    end

    always_comb begin
        dist_next    = (result.best_sum[PART_W-1:DIST_W] != '0) ? DIST_MAX
                                                                : result.best_sum[DIST_W-1:0];
        inertia_wide = {1'b0, inertia_reg} + (INERTIA_W+1)'(dist_next);
        inertia_next = inertia_wide[INERTIA_W] ? INER_MAX : inertia_wide[INERTIA_W-1:0];
    end

    kmnc_centroid_mem u_cmem (
        .aclk    (aclk),
        .wr_en   (in_beat && (action_t'(s_tuser) == ACT_WRITE)),
        .wr_addr ({in_cidx, in_fidx}),
        .wr_data (in_value),
        .rd_en   (issue.vld),
        .rd_addr ({c_reg, fi_reg}),
        .rd_data (cent_data)
    );

    kmnc_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue       (issue),
        .point_value (value_reg),
        .cent_data   (cent_data),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            active_centroids_reg <= CNT_W'(1);
            active_features_reg  <= CNT_W'(16);
            inertia_reg          <= '0;
            m_tvalid_reg         <= 1'b0;
            c_reg                <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ACTIVE_CENTROIDS: active_centroids_reg <= cfg_wdata;
                    REG_ACTIVE_FEATURES:  active_features_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (finish_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        case (action_t'(s_tuser))
                            ACT_CLEAR: inertia_reg <= '0;
                            ACT_POINT: begin
                                if ({1'b0, in_fidx} < nf_eff) begin
                                    fi_reg        <= in_fidx;
                                    value_reg     <= in_value;
                                    last_item_reg <= ({1'b0, in_fidx} == nf_eff - CNT_W'(1));
                                    c_reg         <= '0;
                                    state_reg     <= ST_ISSUE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ISSUE: begin
                    if (issue.last) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        c_reg <= c_reg + CIDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (result.done) begin
                        state_reg <= last_item_reg ? ST_FINISH : ST_IDLE;
                    end
                end
                ST_FINISH: begin
                    // Waits here only while an earlier result is still stalled.
                    if (finish_fire) begin
                        label_reg     <= result.label;
                        dist_reg      <= dist_next;
                        inertia_reg   <= inertia_next;
                        m_inertia_reg <= inertia_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_inertia_reg, dist_reg, label_reg};

endmodule

`default_nettype wire

>>> hdl/kmnc_checker.sv
// Port-level checks for kmeans_nearest_centroid, attached by the bind below.
// Depends on kmnc_pkg.
`default_nettype none

module kmnc_checker
    import kmnc_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [ACTION_W-1:0]  s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // The running sum always includes the distance just reported.
    a_inertia_covers_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:CIDX_W+DIST_W]
                      >= INERTIA_W'(m_tdata[CIDX_W+DIST_W-1:CIDX_W])))
        else $error("inertia sum below reported distance");

    // Table writes never stall the input side.
    a_write_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_WRITE) |=> s_tready)
        else $error("input stalled after a centroid write beat");

endmodule

bind kmeans_nearest_centroid kmnc_checker u_kmnc_checker (.*);

`default_nettype wire

>>> tb/sv/kmeans_nearest_centroid_tb.sv
// Self-checking testbench for kmeans_nearest_centroid: a directed table, a distance
// saturation run and randomized phases, checked against typed results or an in-bench predictor.
// Depends on kmnc_pkg and the kmeans_nearest_centroid RTL only.

module kmeans_nearest_centroid_tb;
    import kmnc_pkg::*;

    typedef longint unsigned u64_t;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam u64_t PART_MAX    = (u64_t'(1) << PART_W) - 1;
    localparam u64_t DIST_MAX    = (u64_t'(1) << DIST_W) - 1;
    localparam u64_t INERTIA_MAX = (u64_t'(1) << INERTIA_W) - 1;

    localparam int SETTLE_CYCLES    = 32;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DIR_ROWS         = 22;
    localparam int SAT_BEATS        = 40;
    localparam int RANDOM_ITEMS     = 180;
    localparam int NUM_PHASES       = 8;
    localparam int TIMEOUT_CYCLES   = 1000000;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
        logic [FIDX_W-1:0]   fidx;
        logic [CIDX_W-1:0]   cidx;
    } beat_t;

    // Same bit order as m_tdata, so a result beat casts straight into it.
    typedef struct packed {
        logic [INERTIA_W-1:0] inertia;
        logic [DIST_W-1:0]    distance;
        logic [CIDX_W-1:0]    label;
    } assign_t;

    typedef struct packed {
        beat_t   beat;
        logic    typed;
        assign_t want;
    } row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [ACTION_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_wdata;

    kmeans_nearest_centroid dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state.
    logic [VALUE_W-1:0] centroid_table [MAX_CENTROIDS*MAX_FEATURES];
    u64_t               partial_sum [MAX_CENTROIDS];
    u64_t               inertia_total;
    logic [CNT_W-1:0]   reg_centroids;
    logic [CNT_W-1:0]   reg_features;

    assign_t pending_assignments [$];

    bit sender_idle   = 1'b1;
    bit recv_idle     = 1'b1;
    bit long_hold_req = 1'b0;
    int hold_left     = 0;
    int burst_left    = 0;

    int fail_count        = 0;
    int checked_results   = 0;
    int predicted_results = 0;
    int counted_items     = 0;
    int beats_sent        = 0;
    int settings_used     = 0;

    logic [CNT_W-1:0] phase_centroids [NUM_PHASES] =
        '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5, 5'd3, 5'd16};
    logic [CNT_W-1:0] phase_features [NUM_PHASES] =
        '{5'd16, 5'd0, 5'd31, 5'd16, 5'd1, 5'd3, 5'd9, 5'd4};

    row_t directed_rows [DIR_ROWS];

    function automatic int eff_count(input logic [CNT_W-1:0] v, input int maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic bit predict_assignment(input beat_t b, output assign_t r);
        int   nc;
        int   nf;
        int   best;
        longint diff;
        u64_t best_d;
        u64_t dist_sat;
        r  = '0;
        nc = eff_count(reg_centroids, MAX_CENTROIDS);
        nf = eff_count(reg_features, MAX_FEATURES);
        if (b.action == ACT_WRITE) begin
            centroid_table[{b.cidx, b.fidx}] = b.value;
            return 1'b0;
        end
        if (b.action == ACT_CLEAR) begin
            inertia_total = 0;
            return 1'b0;
        end
        if (b.action != ACT_POINT || int'(b.fidx) >= nf) return 1'b0;

        if (b.fidx == '0) begin
            foreach (partial_sum[c]) partial_sum[c] = 0;
        end
        for (int c = 0; c < nc; c++) begin
            diff = longint'($signed(b.value))
                 - longint'($signed(centroid_table[{CIDX_W'(c), b.fidx}]));
            partial_sum[c] += u64_t'(diff * diff);
            if (partial_sum[c] > PART_MAX) partial_sum[c] = PART_MAX;
        end
        if (int'(b.fidx) != nf - 1) return 1'b0;

        best   = 0;
        best_d = partial_sum[0];
        for (int c = 1; c < nc; c++) begin
            if (partial_sum[c] < best_d) begin
                best_d = partial_sum[c];
                best   = c;
            end
        end
        dist_sat = (best_d > DIST_MAX) ? DIST_MAX : best_d;
        inertia_total += dist_sat;
        if (inertia_total > INERTIA_MAX) inertia_total = INERTIA_MAX;
        r.label    = CIDX_W'(best);
        r.distance = dist_sat[DIST_W-1:0];
        r.inertia  = inertia_total[INERTIA_W-1:0];
        return 1'b1;
    endfunction

    function automatic row_t dir_row(input logic [ACTION_W-1:0] act, input int ci,
                                     input int fi, input logic [VALUE_W-1:0] v,
                                     input bit typed = 1'b0, input int lbl = 0,
                                     input u64_t want_dist = 0, input u64_t inert = 0);
        row_t r;
        r.beat.action  = act;
        r.beat.cidx    = CIDX_W'(ci);
        r.beat.fidx    = FIDX_W'(fi);
        r.beat.value   = v;
        r.typed        = typed;
        r.want.label   = CIDX_W'(lbl);
        r.want.distance = want_dist[DIST_W-1:0];
        r.want.inertia = inert[INERTIA_W-1:0];
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Feature values often sit on or next to a centroid so that small distances
    // and ties between duplicated rows turn up.
    function automatic logic [VALUE_W-1:0] pick_feature(input logic [FIDX_W-1:0] fi,
                                                        input int nc);
        logic [VALUE_W-1:0] base;
        base = centroid_table[{CIDX_W'($urandom_range(0, nc - 1)), fi}];
        case ($urandom_range(0, 9))
            0, 1: return base;
            2: return base + VALUE_W'($urandom_range(0, 3));
            3: return 16'h8000;
            4: return 16'h7FFF;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic send_beat(input beat_t b, input bit typed = 1'b0,
                             input assign_t typed_want = '0);
        assign_t predicted;
        bit      produces;
        int      nf;
        @(negedge aclk);
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = b.action;
        s_tdata  = {b.value, b.fidx, b.cidx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        nf = eff_count(reg_features, MAX_FEATURES);
        beats_sent++;
        if (b.action != ACT_UNUSED && !(b.action == ACT_POINT && int'(b.fidx) >= nf))
            counted_items++;
        produces = predict_assignment(b, predicted);
        if (produces) begin
            predicted_results++;
            pending_assignments.insert(pending_assignments.size(),
                                       typed ? typed_want : predicted);
        end
    endtask

    task automatic send_fields(input logic [ACTION_W-1:0] act, input int ci, input int fi,
                               input logic [VALUE_W-1:0] v);
        beat_t b;
        b.action = act;
        b.cidx   = CIDX_W'(ci);
        b.fidx   = FIDX_W'(fi);
        b.value  = v;
        send_beat(b);
    endtask

    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_assignments.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        drain_pipeline();
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == REG_ACTIVE_CENTROIDS) reg_centroids = val;
        else reg_features = val;
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(4 * TIMEOUT_CYCLES);
        $display("timeout with %0d results outstanding", pending_assignments.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: short random stalls, plus one long hold on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                m_tready = 1'b0;
            end else if (recv_idle && $urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(1, 3) - 1;
                m_tready   = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        assign_t got;
        assign_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = assign_t'(m_tdata);
            checked_results++;
            if (pending_assignments.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat: label %0d distance %0d inertia %0d",
                             got.label, got.distance, got.inertia);
            end else begin
                want = pending_assignments.pop_front();
                if (got.label != want.label || got.distance != want.distance ||
                    got.inertia != want.inertia) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: label %0d/%0d dist %0d/%0d inertia %0d/%0d (exp/act)",
                                 want.label, got.label, want.distance, got.distance,
                                 want.inertia, got.inertia);
                end
            end
        end
    end

    initial begin
        int nc;
        int nf;
        int len;
        int src;
        int dst;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn   = 1'b0;

        foreach (centroid_table[i]) centroid_table[i] = '0;
        foreach (partial_sum[c]) partial_sum[c] = 0;
        inertia_total = 0;
        reg_centroids = 5'd1;
        reg_features  = 5'd16;

        phase_centroids[NUM_PHASES-1] = CNT_W'($urandom_range(1, 16));
        phase_features[NUM_PHASES-1]  = CNT_W'($urandom_range(1, 16));

        // Two centroids of two features; rows with a typed result are the
        // exact hits, the extremes and the tie.
        directed_rows = '{
            dir_row(ACT_WRITE, 0, 0, 16'h0000),
            dir_row(ACT_WRITE, 0, 1, 16'h0000),
            dir_row(ACT_WRITE, 1, 0, 16'h7FFF),
            dir_row(ACT_WRITE, 1, 1, 16'h8000),
            dir_row(ACT_POINT, 0, 0, 16'h0000),
            dir_row(ACT_POINT, 0, 1, 16'h0000, 1'b1, 0, 0, 0),
            dir_row(ACT_POINT, 0, 0, 16'h7FFF),
            dir_row(ACT_POINT, 0, 1, 16'h8000, 1'b1, 1, 0, 0),
            dir_row(ACT_POINT, 0, 0, 16'h8000),
            dir_row(ACT_POINT, 0, 1, 16'h7FFF, 1'b1, 0, 2147418113, 2147418113),
            dir_row(ACT_WRITE, 1, 0, 16'h0000),
            dir_row(ACT_WRITE, 1, 1, 16'h0000),
            dir_row(ACT_POINT, 0, 0, 16'h0005),
            dir_row(ACT_POINT, 0, 1, 16'hFFF9, 1'b1, 0, 74, 2147418187),
            dir_row(ACT_CLEAR, 0, 0, 16'h0000),
            dir_row(ACT_UNUSED, 15, 15, 16'hFFFF),
            dir_row(ACT_POINT, 0, 3, 16'h0064),
            dir_row(ACT_POINT, 15, 15, 16'h1234),
            dir_row(ACT_POINT, 0, 1, 16'h0003),
            dir_row(ACT_WRITE, 15, 15, 16'h8000),
            dir_row(ACT_POINT, 0, 0, 16'h8000),
            dir_row(ACT_POINT, 0, 1, 16'h8000)
        };

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_reg(REG_ACTIVE_CENTROIDS, 5'd2);
        write_reg(REG_ACTIVE_FEATURES, 5'd2);
        settings_used++;
        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        // Fill the whole centroid table so that any later setting reads written words.
        for (int i = 0; i < MAX_CENTROIDS * MAX_FEATURES; i++)
            send_fields(ACT_WRITE, i / MAX_FEATURES, i % MAX_FEATURES, random_word());

        // Distance saturation: the last feature repeated without a new start keeps
        // adding the largest square until the partial sum pins at its maximum.
        write_reg(REG_ACTIVE_CENTROIDS, 5'd1);
        settings_used++;
        send_fields(ACT_WRITE, 0, 0, 16'h7FFF);
        send_fields(ACT_WRITE, 0, 1, 16'h7FFF);
        send_fields(ACT_POINT, 0, 0, 16'h8000);
        repeat (SAT_BEATS) send_fields(ACT_POINT, 0, 1, 16'h8000);
        send_fields(ACT_CLEAR, 0, 0, VALUE_W'($urandom));

        counted_items = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_ACTIVE_CENTROIDS, phase_centroids[p]);
            write_reg(REG_ACTIVE_FEATURES, phase_features[p]);
            settings_used++;
            if (p == NUM_PHASES - 1) begin
                sender_idle = 1'b0;
                recv_idle   = 1'b0;
            end
            nc = eff_count(reg_centroids, MAX_CENTROIDS);
            nf = eff_count(reg_features, MAX_FEATURES);
            // With one feature per point every beat yields a result, so a long hold
            // here backs the block up into its input.
            if (p == 1) long_hold_req = 1'b1;
            while (counted_items < (p + 1) * RANDOM_ITEMS / NUM_PHASES) begin
                case ($urandom_range(0, 99)) inside
                    [0:59]: begin
                        for (int f = 0; f < nf; f++)
                            send_fields(ACT_POINT, $urandom_range(0, 15), f,
                                        pick_feature(FIDX_W'(f), nc));
                    end
                    [60:69]: begin
                        repeat ($urandom_range(1, 4))
                            send_fields(ACT_WRITE, $urandom_range(0, 15),
                                        $urandom_range(0, 15), random_word());
                    end
                    [70:74]: begin
                        src = $urandom_range(0, nc - 1);
                        dst = $urandom_range(0, 15);
                        for (int f = 0; f < nf; f++)
                            send_fields(ACT_WRITE, dst, f,
                                        centroid_table[{CIDX_W'(src), FIDX_W'(f)}]);
                    end
                    [75:79]: send_fields(ACT_CLEAR, $urandom_range(0, 15),
                                         $urandom_range(0, 15), VALUE_W'($urandom));
                    [80:84]: send_fields(ACT_UNUSED, $urandom_range(0, 15),
                                         $urandom_range(0, 15), VALUE_W'($urandom));
                    [85:89]: begin
                        if (nf < MAX_FEATURES)
                            send_fields(ACT_POINT, $urandom_range(0, 15),
                                        $urandom_range(nf, 15), VALUE_W'($urandom));
                    end
                    [90:94]: begin
                        // A point cut short before its last feature.
                        len = (nf > 1) ? $urandom_range(1, nf - 1) : 1;
                        for (int f = 0; f < len; f++)
                            send_fields(ACT_POINT, 0, f, pick_feature(FIDX_W'(f), nc));
                    end
                    default: begin
                        // Features in no particular order, repeats included.
                        repeat ($urandom_range(1, 4))
                            send_fields(ACT_POINT, $urandom_range(0, 15),
                                        $urandom_range(0, nf - 1), random_word());
                    end
                endcase
            end
        end

        drain_pipeline();
        $display("%0d beats driven, %0d results checked across %0d register settings,",
                 beats_sent, checked_results, settings_used);
        $display("including ties, ignored beats, stalls and saturated distances.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
